/* sv/positional_list_engine_defines.svh */
// Assertion macros shared by the positional list engine RTL
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/plc_pkg.sv */
// Shared types and constants of the positional list engine
package plc_pkg;

    localparam int DATA_W         = 32;
    localparam int KIND_W         = 2;
    localparam int POS_W          = 8;
    localparam int STAT_W         = 3;
    localparam int CNT_W          = 8;
    localparam int LIST_DEPTH_DEF = 128;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_FIND   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic              shift;
        logic [DATA_W-1:0] tail;
    } chain_drive_t;

endpackage

/* sv/positional_list_engine.sv */
// Top level of the positional list engine: ring of list cells and sequencer
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   request  | s_valid / s_ready  | s_kind, s_position, s_value
//   result   | m_valid / m_ready  | m_status, m_removed_value, m_found_position,
//            |                    | m_count_after
//
// A request that passes its checks rotates the whole cell ring once in S_RUN, one cell
// step per shift; the result register is then marked valid as the sequencer returns to
// S_IDLE. A rejected request (full, bad position, empty) is answered without a rotation.
// A new request waits while a result is held unaccepted and while a rotation runs.
// Reset clears the entry count and both handshakes; cell contents are left as they are.
module positional_list_engine #(
    parameter int LIST_DEPTH = plc_pkg::LIST_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [plc_pkg::KIND_W-1:0] s_kind,
    input  logic [plc_pkg::POS_W-1:0]  s_position,
    input  logic [plc_pkg::DATA_W-1:0] s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [plc_pkg::STAT_W-1:0] m_status,
    output logic [plc_pkg::DATA_W-1:0] m_removed_value,
    output logic [plc_pkg::CNT_W-1:0]  m_found_position,
    output logic [plc_pkg::CNT_W-1:0]  m_count_after
);
    import plc_pkg::*;

    chain_drive_t      drive;
    logic [DATA_W-1:0] cell_q [LIST_DEPTH];

    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] din;
        if (k == LIST_DEPTH - 1) begin : g_tail
            assign din = drive.tail;
        end else begin : g_body
            assign din = cell_q[k+1];
        end
        plc_cell u_cell (
            .aclk  (aclk),
            .shift (drive.shift),
            .din   (din),
            .dout  (cell_q[k])
        );
    end

    plc_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_position       (s_position),
        .s_value          (s_value),
        .head             (cell_q[0]),
        .second           (cell_q[1]),
        .drive            (drive),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_count_after    (m_count_after)
    );

endmodule

/* sv/plc_cell.sv */
// One storage cell of the list ring: loads din on shift, the next cell's entry or, for the last cell, the tail drive
module plc_cell (
    input  logic                       aclk,
    input  logic                       shift,
    input  logic [plc_pkg::DATA_W-1:0] din,
    output logic [plc_pkg::DATA_W-1:0] dout
);
    import plc_pkg::*;

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

/* sv/plc_ctrl.sv */
// Request sequencer: checks, ring rotation control, search and result register
`include "positional_list_engine_defines.svh"

module plc_ctrl #(
    parameter int LIST_DEPTH = plc_pkg::LIST_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [plc_pkg::KIND_W-1:0] s_kind,
    input  logic [plc_pkg::POS_W-1:0]  s_position,
    input  logic [plc_pkg::DATA_W-1:0] s_value,
    input  logic [plc_pkg::DATA_W-1:0] head,
    input  logic [plc_pkg::DATA_W-1:0] second,
    output plc_pkg::chain_drive_t      drive,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [plc_pkg::STAT_W-1:0] m_status,
    output logic [plc_pkg::DATA_W-1:0] m_removed_value,
    output logic [plc_pkg::CNT_W-1:0]  m_found_position,
    output logic [plc_pkg::CNT_W-1:0]  m_count_after
);
    import plc_pkg::*;

    localparam int IW = (LIST_DEPTH > 2) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [IW-1:0]    LAST    = IW'(LIST_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    kind_t             kind_reg, kind_next;
    logic [CNT_W-1:0]  at_reg, at_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_removed_reg, m_removed_next;
    logic [CNT_W-1:0]  m_found_reg, m_found_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic              pos_ok;
    logic [CNT_W-1:0]  idx8;
    logic [CNT_W-1:0]  pos_m1;
    status_t           req_status;
    logic              req_run;
    logic [CNT_W-1:0]  req_count;
    logic [CNT_W-1:0]  req_at;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg >= DEPTH_C);
    assign empty   = (count_reg == '0);
    assign pos_ok  = (s_position != '0) && (CNT_W'(s_position) <= count_reg);
    assign pos_m1  = CNT_W'(s_position) - CNT_W'(1);
    assign idx8    = CNT_W'(idx_reg);

    always_comb begin
        req_status = ST_OK;
        req_run    = 1'b0;
        req_count  = count_reg;
        req_at     = count_reg;
        unique case (kind_t'(s_kind))
            KIND_APPEND: begin
                if (full) begin
                    req_status = ST_FULL;
                end else begin
                    req_run   = 1'b1;
                    req_count = count_reg + CNT_W'(1);
                end
            end
            KIND_INSERT: begin
                if (full) begin
                    req_status = ST_FULL;
                end else if (!pos_ok) begin
                    req_status = ST_BADPOS;
                end else begin
                    req_run   = 1'b1;
                    req_count = count_reg + CNT_W'(1);
                    req_at    = pos_m1;
                end
            end
            KIND_DELETE: begin
                if (empty) begin
                    req_status = ST_EMPTY;
                end else if (!pos_ok) begin
                    req_status = ST_BADPOS;
                end else begin
                    req_run   = 1'b1;
                    req_count = count_reg - CNT_W'(1);
                    req_at    = pos_m1;
                end
            end
            KIND_FIND: begin
                if (empty) begin
                    req_status = ST_EMPTY;
                end else begin
                    req_status = ST_NOTFOUND;
                    req_run    = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        drive.shift = (state_reg == S_RUN);
        drive.tail  = head;
        unique case (kind_reg) inside
            KIND_APPEND, KIND_INSERT: begin
                if (idx8 < at_reg) begin
                    drive.tail = head;
                end else if (idx8 == at_reg) begin
                    drive.tail = key_reg;
                end else begin
                    drive.tail = prev_reg;
                end
            end
            KIND_DELETE: begin
                drive.tail = (idx8 < at_reg) ? head : second;
            end
            KIND_FIND: begin
                drive.tail = head;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        at_next        = at_reg;
        key_next       = key_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_removed_next = m_removed_reg;
        m_found_next   = m_found_reg;
        m_count_next   = m_count_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next      = kind_t'(s_kind);
                    key_next       = s_value;
                    at_next        = req_at;
                    count_next     = req_count;
                    m_status_next  = req_status;
                    m_removed_next = '0;
                    m_found_next   = '0;
                    m_count_next   = req_count;
                    idx_next       = '0;
                    if (req_run) begin
                        state_next = S_RUN;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_RUN: begin
                idx_next  = idx_reg + IW'(1);
                prev_next = head;
                if ((kind_reg == KIND_DELETE) && (idx8 == at_reg)) begin
                    m_removed_next = head;
                end
                if ((kind_reg == KIND_FIND) && (idx8 < count_reg) && (head == key_reg)
                        && (m_status_reg == ST_NOTFOUND)) begin
                    m_status_next = ST_OK;
                    m_found_next  = idx8 + CNT_W'(1);
                end
                if (idx_reg == LAST) begin
                    idx_next     = '0;
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        at_reg        <= at_next;
        key_reg       <= key_next;
        prev_reg      <= prev_next;
        m_status_reg  <= m_status_next;
        m_removed_reg <= m_removed_next;
        m_found_reg   <= m_found_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_removed_value  = m_removed_reg;
    assign m_found_position = m_found_reg;
    assign m_count_after    = m_count_reg;

    `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C, "entry count above depth")
    `PLE_ASSERT_NOW(a_slot_free_in_run, state_reg == S_RUN, !m_valid_reg,
        "result slot busy during rotation")
    `PLE_ASSERT_NEXT(a_run_ends_valid, (state_reg == S_RUN) && (idx_reg == LAST),
        m_valid_reg && (state_reg == S_IDLE), "rotation ended without result")
    `PLE_ASSERT_NEXT(a_count_on_accept, !accept, $stable(count_reg),
        "entry count changed without request")

endmodule
